// File: design/tcps_pkg.sv
// Package for the template character-class pattern search: types, constants, register indexes.
`default_nettype none
package tcps_pkg;

	localparam int MaxTemplateLenDef = 16;
	localparam int MaxBufferLenDef   = 65535;
	localparam int CfgIdxW           = 3;
	localparam int CfgDataW          = 64;
	localparam int TmplLenW          = 5;
	localparam int PosW              = 16;

	localparam logic [CfgIdxW-1:0] RegTmplLow  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegTmplHigh = 3'd1;
	localparam logic [CfgIdxW-1:0] RegTmplLen  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegDigitWc  = 3'd3;
	localparam logic [CfgIdxW-1:0] RegLetterWc = 3'd4;
	localparam logic [CfgIdxW-1:0] RegAlnumWc  = 3'd5;
	localparam logic [CfgIdxW-1:0] RegExtraChr = 3'd6;

	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharDot   = 8'h2E;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic            found;
		logic [PosW-1:0] match_position;
		logic            overflow;
	} out_word_t;

	typedef struct packed {
		logic [7:0] digit_wc;
		logic [7:0] letter_wc;
		logic [7:0] alnum_wc;
		logic [7:0] extra_chr;
	} class_cfg_t;

	typedef struct packed {
		logic step;
		logic clear;
	} cell_ctl_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
	endfunction

endpackage
`default_nettype wire

// File: design/tcps_cell.sv
// One template position: class compare against the byte and one partial-match bit.
`default_nettype none
module tcps_cell
	import tcps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctl_t  ctl,
	input  wire class_cfg_t cls,
	input  wire logic [7:0] tchar,
	input  wire logic [7:0] data_byte,
	input  wire logic       active,
	input  wire logic       prev,
	output logic            match_q,
	output logic            match_d
);

	logic acc;

	always_comb begin
		if (tchar == cls.digit_wc) begin
			acc = is_digit(data_byte) || (data_byte == CharMinus) || (data_byte == CharDot) ||
				(data_byte == cls.extra_chr) || (data_byte == tchar);
		end else if (tchar == cls.letter_wc) begin
			acc = is_letter(data_byte) || (data_byte == tchar);
		end else if (tchar == cls.alnum_wc) begin
			acc = is_digit(data_byte) || is_letter(data_byte) || (data_byte == tchar);
		end else begin
			acc = (data_byte == tchar);
		end
	end

	assign match_d = prev & acc & active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
		end else if (ctl.step) begin
			match_q <= match_d;
		end
	end

endmodule
`default_nettype wire

// File: design/template_class_pattern_search.sv
// Top level: config registers, chain of match cells, buffer counter and output register.
// An accepted byte that completes a match or ends a buffer has its result word registered in the output register.
// Throughput: one byte per cycle unless stalled; all cells step until a match or the limit.
// A new byte is taken while a result waits, unless that result is stalled by out_ready.
// Reset: asynchronous, clears config registers, match bits, counter and flags.
`default_nettype none
module template_class_pattern_search
	import tcps_pkg::*;
#(
	parameter int MaxTemplateLen = MaxTemplateLenDef,
	parameter int MaxBufferLen   = MaxBufferLenDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_word_t            in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_word_t                out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	localparam int CntW = $clog2(MaxBufferLen + 1);
	localparam int LenW = $clog2(MaxTemplateLen + 1);

	logic [127:0]        tmpl_q;
	logic [TmplLenW-1:0] tlen_q;
	class_cfg_t          cls_q;

	logic [CntW-1:0] count_q;
	logic            done_q;
	logic            ovf_q;
	logic            out_valid_q;
	out_word_t       out_data_q;

	logic [LenW-1:0]           len_sat;
	logic                      in_fire;
	logic                      at_limit;
	cell_ctl_t                 ctl;
	logic [MaxTemplateLen-1:0] m_q;
	logic [MaxTemplateLen-1:0] m_d;
	logic [MaxTemplateLen-1:0] last_pos;
	logic                      hit;
	logic                      emit;
	out_word_t                 res;
	logic [CntW-1:0]           pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmpl_q <= '0;
			tlen_q <= '0;
			cls_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegTmplLow:  tmpl_q[63:0]    <= cfg_data;
				RegTmplHigh: tmpl_q[127:64]  <= cfg_data;
				RegTmplLen:  tlen_q          <= cfg_data[TmplLenW-1:0];
				RegDigitWc:  cls_q.digit_wc  <= cfg_data[7:0];
				RegLetterWc: cls_q.letter_wc <= cfg_data[7:0];
				RegAlnumWc:  cls_q.alnum_wc  <= cfg_data[7:0];
				RegExtraChr: cls_q.extra_chr <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign len_sat = (tlen_q > TmplLenW'(MaxTemplateLen)) ? LenW'(MaxTemplateLen)
		: LenW'(tlen_q);

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign at_limit = (count_q >= CntW'(MaxBufferLen));

	assign ctl.step  = in_fire && !done_q && !at_limit;
	assign ctl.clear = in_fire && in_data.last_byte;

	genvar p;
	generate
		for (p = 0; p < MaxTemplateLen; p++) begin : g_cell
			logic prev;
			if (p == 0) begin : g_head
				assign prev = 1'b1;
			end else begin : g_link
				assign prev = m_q[p-1];
			end
			assign last_pos[p] = (LenW'(p + 1) == len_sat);
			tcps_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.cls       (cls_q),
				.tchar     (tmpl_q[8*p +: 8]),
				.data_byte (in_data.data_byte),
				.active    (LenW'(p) < len_sat),
				.prev      (prev),
				.match_q   (m_q[p]),
				.match_d   (m_d[p])
			);
		end
	endgenerate

	assign hit = ctl.step && (|(m_d & last_pos));
	assign pos = count_q + CntW'(1) - CntW'(len_sat);

	always_comb begin
		res  = '0;
		emit = 1'b0;
		if (hit) begin
			emit               = 1'b1;
			res.found          = 1'b1;
			res.match_position = PosW'(pos);
			res.overflow       = ovf_q;
		end else if (in_fire && !done_q && in_data.last_byte) begin
			emit         = 1'b1;
			res.overflow = ovf_q || at_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (ctl.clear) begin
			count_q <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (in_fire && !done_q) begin
			if (at_limit) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CntW'(1);
				done_q  <= hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// File: tb/tb_template_class_pattern_search.sv
// Testbench for the template pattern search: directed and random buffers, each result word checked.
module tb_template_class_pattern_search;
	timeunit 1ns;
	timeprecision 1ps;
	import tcps_pkg::*;

	localparam int HoldCycles = 300;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_word_t            in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_word_t           out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;

	logic [63:0] cfg_tmpl_lo = '0;
	logic [63:0] cfg_tmpl_hi = '0;
	logic [4:0]  cfg_len     = '0;
	logic [7:0]  cfg_digit   = '0;
	logic [7:0]  cfg_letter  = '0;
	logic [7:0]  cfg_alnum   = '0;
	logic [7:0]  cfg_extra   = '0;

	logic [15:0] srch_partial = '0;
	int          srch_count   = 0;
	logic        srch_done    = 1'b0;
	logic        srch_ovf     = 1'b0;

	out_word_t expected_hits[$];
	int        mismatch_count = 0;
	int        words_sent     = 0;
	logic      gaps_on        = 1'b1;
	logic      hold_req       = 1'b0;
	logic      hold_seen      = 1'b0;
	int        hold_left      = 0;

	template_class_pattern_search uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic byte_is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic byte_is_letter(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] tmpl_at(input int p);
		logic [127:0] all_chars;
		all_chars = {cfg_tmpl_hi, cfg_tmpl_lo};
		return all_chars[8*p +: 8];
	endfunction

	function automatic logic class_accepts(input logic [7:0] t, input logic [7:0] b);
		if (t == cfg_digit)
			return byte_is_digit(b) || b == CharMinus || b == CharDot || b == cfg_extra || b == t;
		if (t == cfg_letter)
			return byte_is_letter(b) || b == t;
		if (t == cfg_alnum)
			return byte_is_digit(b) || byte_is_letter(b) || b == t;
		return b == t;
	endfunction

	task automatic search_step(input in_word_t w);
		int          len;
		logic [15:0] acc;
		logic [15:0] mask;
		out_word_t   r;
		logic        hit;
		len = (cfg_len > MaxTemplateLenDef) ? MaxTemplateLenDef : int'(cfg_len);
		hit = 1'b0;
		if (!srch_done) begin
			if (srch_count >= MaxBufferLenDef) begin
				srch_ovf = 1'b1;
			end else begin
				acc = '0;
				for (int p = 0; p < len; p++)
					acc[p] = class_accepts(tmpl_at(p), w.data_byte);
				mask = (len == 0) ? 16'h0 : 16'((32'd1 << len) - 1);
				srch_partial = {srch_partial[14:0], 1'b1} & acc & mask;
				if (len != 0 && srch_partial[len-1]) begin
					r.found          = 1'b1;
					r.match_position = 16'(srch_count + 1 - len);
					r.overflow       = srch_ovf;
					expected_hits.push_back(r);
					srch_done = 1'b1;
					hit       = 1'b1;
				end
				srch_count++;
			end
			if (w.last_byte && !hit) begin
				r          = '0;
				r.overflow = srch_ovf;
				expected_hits.push_back(r);
			end
		end
		if (w.last_byte) begin
			srch_partial = '0;
			srch_count   = 0;
			srch_done    = 1'b0;
			srch_ovf     = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected result word", 32'(out_data), 0);
			end else begin
				want = expected_hits.pop_front();
				if (out_data.found !== want.found)
					report_mismatch("found", 32'(out_data.found), 32'(want.found));
				if (out_data.match_position !== want.match_position)
					report_mismatch("match_position", 32'(out_data.match_position),
						32'(want.match_position));
				if (out_data.overflow !== want.overflow)
					report_mismatch("overflow", 32'(out_data.overflow), 32'(want.overflow));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(gaps_on && $urandom_range(99) < 14);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic l);
		in_word_t w;
		w.data_byte = b;
		w.last_byte = l;
		if (gaps_on && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		search_step(w);
		words_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			RegTmplLow:  cfg_tmpl_lo = val;
			RegTmplHigh: cfg_tmpl_hi = val;
			RegTmplLen:  cfg_len     = val[4:0];
			RegDigitWc:  cfg_digit   = val[7:0];
			RegLetterWc: cfg_letter  = val[7:0];
			RegAlnumWc:  cfg_alnum   = val[7:0];
			RegExtraChr: cfg_extra   = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic cfg_write_all(input logic [127:0] chars, input logic [4:0] len,
			input logic [7:0] dw, input logic [7:0] lw, input logic [7:0] aw,
			input logic [7:0] ex);
		cfg_write(RegTmplLow, chars[63:0]);
		cfg_write(RegTmplHigh, chars[127:64]);
		cfg_write(RegTmplLen, 64'(len));
		cfg_write(RegDigitWc, 64'(dw));
		cfg_write(RegLetterWc, 64'(lw));
		cfg_write(RegAlnumWc, 64'(aw));
		cfg_write(RegExtraChr, 64'(ex));
	endtask

	function automatic logic [7:0] accepted_byte(input logic [7:0] t);
		if (t == cfg_digit) begin
			case ($urandom_range(4))
				0: return CharMinus;
				1: return CharDot;
				2: return cfg_extra;
				3: return t;
				default: return rand_digit();
			endcase
		end
		if (t == cfg_letter)
			return $urandom_range(3) == 0 ? t : rand_letter();
		if (t == cfg_alnum) begin
			case ($urandom_range(2))
				0: return t;
				1: return rand_letter();
				default: return rand_digit();
			endcase
		end
		return t;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(7))
			0: return rand_digit();
			1: return rand_letter();
			2: return CharMinus;
			3: return CharDot;
			4: return cfg_extra;
			5: return $urandom_range(1) ? cfg_digit : ($urandom_range(1) ? cfg_letter : cfg_alnum);
			6: return 8'($urandom_range(255));
			default: return tmpl_at($urandom_range(15));
		endcase
	endfunction

	function automatic logic [7:0] pick_wildcard();
		case ($urandom_range(9))
			0: return 8'h23;
			1: return 8'h3F;
			2: return 8'h2A;
			3: return 8'h25;
			4: return 8'h24;
			5: return 8'h7E;
			6: return 8'($urandom_range(255));
			7: return 8'h00;
			8: return 8'hFF;
			default: return rand_letter();
		endcase
	endfunction

	function automatic logic [7:0] pick_tmpl_char(input logic [7:0] dw, input logic [7:0] lw,
			input logic [7:0] aw);
		case ($urandom_range(9))
			0, 1, 2: return dw;
			3, 4: return lw;
			5: return aw;
			6: return rand_digit();
			7: return rand_letter();
			8: return 8'($urandom_range(255));
			default: return $urandom_range(1) ? CharDot : CharMinus;
		endcase
	endfunction

	task automatic send_random_buffer(output int n);
		int         len;
		int         at;
		logic       embed;
		logic       broken;
		logic [7:0] b;
		len    = (cfg_len > MaxTemplateLenDef) ? MaxTemplateLenDef : int'(cfg_len);
		embed  = len > 0 && $urandom_range(9) < 8;
		broken = $urandom_range(9) < 2;
		n      = embed ? len + $urandom_range(0, 8) : $urandom_range(1, 12);
		at     = embed ? $urandom_range(0, n - len) : -1;
		for (int i = 0; i < n; i++) begin
			if (embed && i >= at && i < at + len && !(broken && i == at + len - 1))
				b = accepted_byte(tmpl_at(i - at));
			else
				b = noise_byte();
			send_word(b, i == n - 1);
		end
	endtask

	task automatic random_config(input int phase);
		logic [127:0] chars;
		logic [4:0]   len;
		logic [7:0]   dw;
		logic [7:0]   lw;
		logic [7:0]   aw;
		logic [7:0]   ex;
		dw = pick_wildcard();
		lw = $urandom_range(7) == 0 ? dw : pick_wildcard();
		aw = $urandom_range(7) == 0 ? lw : pick_wildcard();
		ex = $urandom_range(1) ? 8'($urandom_range(255)) : pick_wildcard();
		for (int p = 0; p < 16; p++)
			chars[8*p +: 8] = pick_tmpl_char(dw, lw, aw);
		len = 5'($urandom_range(1, 6));
		case (phase)
			0: begin
				chars = '1;
				len   = 5'd16;
				dw    = 8'hFF;
				ex    = 8'hFF;
			end
			1: begin
				chars = '0;
				dw    = 8'h00;
				lw    = 8'h00;
				aw    = 8'h00;
				ex    = 8'h00;
				len   = 5'($urandom_range(1, 3));
			end
			2: len = 5'd0;
			3: len = 5'($urandom_range(17, 31));
			4: len = 5'd16;
			default: ;
		endcase
		cfg_write_all(chars, len, dw, lw, aw, ex);
	endtask

	task automatic test_zero_length();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		wait_idle();
	endtask

	task automatic test_char_classes();
		cfg_write_all({64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_512A_4023}, 5'd4,
			8'h23, 8'h40, 8'h2A, 8'h5F);
		send_word("7", 1'b0);
		send_word("z", 1'b0);
		send_word("9", 1'b0);
		send_word("Q", 1'b0);
		send_word("Q", 1'b1);
		send_word(8'h80, 1'b0);
		send_word(".", 1'b0);
		send_word("@", 1'b0);
		send_word("*", 1'b0);
		send_word("Q", 1'b1);
		send_word("_", 1'b0);
		send_word(8'hC1, 1'b0);
		send_word("Q", 1'b1);
		wait_idle();
	endtask

	task automatic test_overlap();
		cfg_write(RegLetterWc, 64'h23);
		send_word("A", 1'b0);
		send_word("-", 1'b0);
		send_word("@", 1'b0);
		send_word("k", 1'b0);
		send_word("Q", 1'b1);
		wait_idle();
	endtask

	task automatic test_max_length();
		cfg_write(RegTmplLow, 64'h2323_2323_2323_2323);
		cfg_write(RegTmplHigh, 64'h2323_2323_2323_2323);
		cfg_write(RegTmplLen, 64'd31);
		for (int i = 0; i < 16; i++)
			send_word(accepted_byte(tmpl_at(i)), i == 15);
		wait_idle();
	endtask

	task automatic test_backpressure();
		cfg_write_all({64'h0, 64'h41}, 5'd1, 8'h23, 8'h40, 8'h2A, 8'h5F);
		hold_req <= ~hold_req;
		for (int i = 0; i < 40; i++)
			send_word($urandom_range(1) ? 8'h41 : noise_byte(), 1'b1);
		wait_idle();
	endtask

	task automatic test_random();
		int n;
		int quota;
		int phase_words;
		for (int phase = 0; phase < 8; phase++) begin
			random_config(phase);
			gaps_on     <= (phase != 5);
			quota       = (phase == 5) ? 130 : 60;
			phase_words = 0;
			while (phase_words < quota) begin
				send_random_buffer(n);
				phase_words += n;
			end
			wait_idle();
		end
		gaps_on <= 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_length();
		test_char_classes();
		test_overlap();
		test_max_length();
		test_backpressure();
		test_random();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: template_class_pattern_search.f
design/tcps_pkg.sv
design/tcps_cell.sv
design/template_class_pattern_search.sv
tb/tb_template_class_pattern_search.sv
